>>> rtl/brace_depth_json_framer_defines.svh
// ----------------------------------------------------------------------------
// Brace-depth framer assertion macros
// Shared checks for the framer RTL; clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRACE_DEPTH_JSON_FRAMER_DEFINES_SVH
`define BRACE_DEPTH_JSON_FRAMER_DEFINES_SVH

// Same-cycle implication check
`define BDJF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check
`define BDJF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bdjf_pkg.sv
// ----------------------------------------------------------------------------
// bdjf_pkg
// Types and constants shared by the brace-depth message framer.
// ----------------------------------------------------------------------------
package bdjf_pkg;

    localparam int LEN_W = 6;

    localparam logic [7:0]       OPEN_CHAR  = 8'h7B;
    localparam logic [7:0]       CLOSE_CHAR = 8'h7D;
    localparam logic [LEN_W-1:0] LEN_SAT    = 6'd63;

    // Configuration register indexes
    localparam logic CFG_KEEP_LAST = 1'b0;
    localparam logic CFG_MAX_LEN   = 1'b1;

    // Result kinds
    localparam logic KIND_MSG    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_STAT
    } t_state;

    typedef struct packed {
        logic             keep_last_only;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [7:0]       msg_byte;
        logic             msg_last;
        logic [LEN_W-1:0] msg_length;
        logic             too_long_seen;
        logic             invalid_seen;
    } t_res;

endpackage

>>> rtl/bdjf_mem.sv
// ----------------------------------------------------------------------------
// bdjf_mem
// Message store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdjf_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bdjf_ctrl.sv
// ----------------------------------------------------------------------------
// bdjf_ctrl
// Brace parser, framing state and read-out sequencer for the message store.
// ----------------------------------------------------------------------------
`include "brace_depth_json_framer_defines.svh"

module bdjf_ctrl
    import bdjf_pkg::*;
#(
    parameter int MSG_CAP   = 32,
    parameter int DEPTH_MAX = 15,
    parameter int AW        = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_packet_end,
    output logic             o_in_stall,
    output logic             o_res_valid,
    output t_res             o_res,
    input  logic             i_res_take,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [7:0]       i_rd_data
);

    localparam int               DW   = $clog2(DEPTH_MAX + 1);
    localparam logic [DW-1:0]    DMAX = DW'(DEPTH_MAX);
    localparam logic [LEN_W-1:0] CAP  = LEN_W'(MSG_CAP);
    localparam logic [AW-1:0]    BANK_BASE = AW'(MSG_CAP);

    // Framing state
    logic             r_open,     n_open;
    logic [DW-1:0]    r_depth,    n_depth;
    logic [LEN_W-1:0] r_len,      n_len;
    logic             r_bank,     n_bank;
    logic             r_held_vld, n_held_vld;
    logic [LEN_W-1:0] r_held_len, n_held_len;
    logic             r_tl,       n_tl;

    // Read-out state
    t_state           r_state, n_state;
    logic             r_rd_bank;
    logic [LEN_W-1:0] r_rd_len;
    logic [LEN_W-1:0] r_is_idx;
    logic [LEN_W-1:0] r_ld_idx;
    logic             r_rd_vld;
    logic             r_stat_pend;
    logic             r_st_tl;
    logic             r_st_inv;

    logic             accept;
    logic             is_open, is_close, appending;
    logic [LEN_W-1:0] limit, len_base, len_app;
    logic             emit_now, emit_bank;
    logic [LEN_W-1:0] emit_len;
    logic             st_tl, st_inv;
    logic             last_byte;

    assign accept    = i_in_valid && !o_in_stall;
    assign is_open   = (i_data_byte == OPEN_CHAR);
    assign is_close  = (i_data_byte == CLOSE_CHAR);
    assign appending = is_open || r_open;
    assign limit     = (i_cfg.max_len < CAP) ? i_cfg.max_len : CAP;
    assign len_base  = (is_open && !r_open) ? '0 : r_len;
    assign len_app   = (len_base < LEN_SAT) ? len_base + 1'b1 : LEN_SAT;

    // Store write: bytes past the bank capacity are only counted
    assign o_wr_en   = accept && appending && (len_base < CAP);
    assign o_wr_addr = (r_bank ? BANK_BASE : '0) + AW'(len_base);
    assign o_wr_data = i_data_byte;

    // Per-word update of the framing state
    always_comb begin
        n_open     = r_open;
        n_depth    = r_depth;
        n_len      = r_len;
        n_bank     = r_bank;
        n_held_vld = r_held_vld;
        n_held_len = r_held_len;
        n_tl       = r_tl;
        emit_now   = 1'b0;
        emit_bank  = r_bank;
        emit_len   = r_len;
        st_tl      = 1'b0;
        st_inv     = 1'b0;

        if (is_open) begin
            if (!r_open) begin
                n_open  = 1'b1;
                n_depth = '0;
            end else if (r_depth < DMAX) begin
                n_depth = r_depth + 1'b1;
            end
        end

        if (appending) begin
            n_len = len_app;
        end

        // Closing brace: top level closes the message
        if (is_close && r_open) begin
            if (r_depth == '0) begin
                n_open = 1'b0;
                n_len  = '0;
                if (len_app > limit) begin
                    n_tl = 1'b1;
                end else if (i_cfg.keep_last_only) begin
                    n_held_vld = 1'b1;
                    n_held_len = len_app;
                    n_bank     = ~r_bank;
                end else begin
                    emit_now  = 1'b1;
                    emit_bank = r_bank;
                    emit_len  = len_app;
                end
            end else begin
                n_depth = r_depth - 1'b1;
            end
        end

        // Packet end: held message, status, drop of an over-long partial
        if (i_packet_end) begin
            if (n_held_vld && i_cfg.keep_last_only) begin
                emit_now  = 1'b1;
                emit_bank = ~n_bank;
                emit_len  = n_held_len;
            end
            n_held_vld = 1'b0;
            st_inv     = !n_open && !is_close;
            if (n_open && (n_len > limit)) begin
                n_tl   = 1'b1;
                n_open = 1'b0;
                n_len  = '0;
            end
            st_tl = n_tl;
            n_tl  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_depth    <= '0;
            r_len      <= '0;
            r_bank     <= 1'b0;
            r_held_vld <= 1'b0;
            r_held_len <= '0;
            r_tl       <= 1'b0;
        end else if (accept) begin
            r_open     <= n_open;
            r_depth    <= n_depth;
            r_len      <= n_len;
            r_bank     <= n_bank;
            r_held_vld <= n_held_vld;
            r_held_len <= n_held_len;
            r_tl       <= n_tl;
        end
    end

    assign last_byte = ((r_ld_idx + 1'b1) == r_rd_len);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (emit_now) begin
                        n_state = ST_EMIT;
                    end else if (i_packet_end) begin
                        n_state = ST_STAT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_res_take && last_byte) begin
                    n_state = r_stat_pend ? ST_STAT : ST_IDLE;
                end
            end
            ST_STAT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_res       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_EMIT: begin
                o_res_valid      = r_rd_vld;
                o_rd_en          = (r_is_idx < r_rd_len) && (!r_rd_vld || i_res_take);
                o_res.kind       = KIND_MSG;
                o_res.msg_byte   = i_rd_data;
                o_res.msg_last   = last_byte;
                o_res.msg_length = r_rd_len;
            end
            ST_STAT: begin
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_STATUS;
                o_res.too_long_seen = r_st_tl;
                o_res.invalid_seen  = r_st_inv;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign o_rd_addr = (r_rd_bank ? BANK_BASE : '0) + AW'(r_is_idx);

    // Read-out bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_is_idx    <= '0;
            r_ld_idx    <= '0;
            r_stat_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd_vld    <= 1'b0;
                r_is_idx    <= '0;
                r_ld_idx    <= '0;
                r_stat_pend <= i_packet_end;
            end else begin
                if (o_rd_en) begin
                    r_is_idx <= r_is_idx + 1'b1;
                end
                if (o_res_valid && i_res_take && (r_state == ST_EMIT)) begin
                    r_ld_idx <= r_ld_idx + 1'b1;
                end
                if (o_rd_en) begin
                    r_rd_vld <= 1'b1;
                end else if (i_res_take) begin
                    r_rd_vld <= 1'b0;
                end
            end
        end
    end

    // Captured with the word: what to read out and the status
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_bank <= emit_bank;
            r_rd_len  <= emit_len;
            r_st_tl   <= st_tl;
            r_st_inv  <= st_inv;
        end
    end

    `BDJF_ASSERT_NOW(a_wr_only_idle, o_wr_en, r_state == ST_IDLE, "store written during read-out")
    `BDJF_ASSERT_NOW(a_rd_vld_in_emit, r_rd_vld, r_state == ST_EMIT, "read data pending outside read-out")
    `BDJF_ASSERT_NOW(a_ld_in_range, r_state == ST_EMIT, r_ld_idx < r_rd_len, "read-out index past message length")
    `BDJF_ASSERT_NEXT(a_emit_ends, (r_state == ST_EMIT) && i_res_take && last_byte, r_state != ST_EMIT, "read-out continues past last byte")

endmodule

>>> rtl/brace_depth_json_framer.sv
// ----------------------------------------------------------------------------
// brace_depth_json_framer
// Frames top-level brace-delimited messages from a packet byte stream.
//
//   channel  dir  handshake           payload
//   in       in   i_in_valid/o_in_stall   i_data_byte, i_packet_end
//   out      out  o_out_valid/i_out_stall o_kind, o_msg_byte, o_msg_last,
//                                      o_msg_length, o_too_long_seen,
//                                      o_invalid_seen
//   cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A byte that produces no result does not stall input; the next can follow at once.
// A byte that releases a message stalls input until read-out ends: the
// store has one read port with registered read data, one byte per cycle.
// A packet-end byte adds a status word, which also stalls input until taken.
// Reset (i_rst_n low, synchronous) closes any message and restores defaults;
// the message store needs no clearing pass. Output stalls stretch read-out.
// ----------------------------------------------------------------------------
module brace_depth_json_framer
    import bdjf_pkg::*;
#(
    parameter int MSG_CAP   = 32,
    parameter int DEPTH_MAX = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_packet_end,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_kind,
    output logic [7:0]       o_msg_byte,
    output logic             o_msg_last,
    output logic [LEN_W-1:0] o_msg_length,
    output logic             o_too_long_seen,
    output logic             o_invalid_seen,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [LEN_W-1:0] i_cfg_data
);

    localparam int DEPTH = 2 * MSG_CAP;
    localparam int AW    = $clog2(DEPTH);

    t_cfg          r_cfg;
    logic          r_out_vld;
    t_res          r_out;
    logic          res_valid;
    t_res          res;
    logic          res_take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_last_only <= 1'b0;
            r_cfg.max_len        <= 6'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEEP_LAST: r_cfg.keep_last_only <= i_cfg_data[0];
                CFG_MAX_LEN:   r_cfg.max_len        <= i_cfg_data;
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

    bdjf_ctrl #(
        .MSG_CAP   (MSG_CAP),
        .DEPTH_MAX (DEPTH_MAX),
        .AW        (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_packet_end (i_packet_end),
        .o_in_stall   (o_in_stall),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    bdjf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: loads when empty or being taken
    assign res_take = res_valid && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_kind          = r_out.kind;
    assign o_msg_byte      = r_out.msg_byte;
    assign o_msg_last      = r_out.msg_last;
    assign o_msg_length    = r_out.msg_length;
    assign o_too_long_seen = r_out.too_long_seen;
    assign o_invalid_seen  = r_out.invalid_seen;

endmodule
